### src/phmb_pkg.sv
package phmb_pkg;

    // Field widths of the item streams and configuration registers
    localparam int COORD_W   = 32;
    localparam int INDEX_W   = 8;
    localparam int CPM_W     = 16;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;

    // Commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X        = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Z        = 2'd1;
    localparam logic [1:0] REG_CELLS_PER_METRE = 2'd2;

    localparam logic [CPM_W-1:0] CPM_RESET = 16'd200;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_z;
        logic [CPM_W-1:0]          cells_per_metre;
    } phmb_cfg_t;

    typedef struct packed {
        logic in_load;
        logic prod_load;
        logic bin_load;
        logic mem_rd;
        logic out_load;
        logic clr_step;
    } phmb_ctl_t;

endpackage

### src/phmb_cfg.sv
module phmb_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output phmb_pkg::phmb_cfg_t cfg
);
    import phmb_pkg::*;

    phmb_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_z        <= '0;
            cfg_reg.cells_per_metre <= CPM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X:        cfg_reg.origin_x        <= $signed(cfg_data);
                REG_ORIGIN_Z:        cfg_reg.origin_z        <= $signed(cfg_data);
                REG_CELLS_PER_METRE: cfg_reg.cells_per_metre <= cfg_data[CPM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

### src/phmb_ctrl.sv
module phmb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_command,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                sweep_last,
    output phmb_pkg::phmb_ctl_t ctl
);
    import phmb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_BIN,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   pending_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_CLEAR: ctl.clr_step  = 1'b1;
            ST_IDLE:  ctl.in_load   = s_tvalid;
            ST_MUL:   ctl.prod_load = 1'b1;
            ST_BIN:   ctl.bin_load  = 1'b1;
            ST_READ:  ctl.mem_rd    = 1'b1;
            ST_DONE:  ctl.out_load  = out_free;
            default:  ctl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            pending_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (sweep_last) begin
                        state_reg   <= pending_reg ? ST_DONE : ST_IDLE;
                        pending_reg <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_command == CMD_CLEAR) begin
                            state_reg   <= ST_CLEAR;
                            pending_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:  state_reg <= ST_BIN;
                ST_BIN:  state_reg <= ST_READ;
                ST_READ: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (ctl.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### src/phmb_dp.sv
module phmb_dp #(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [phmb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  phmb_pkg::phmb_cfg_t                cfg,
    input  phmb_pkg::phmb_ctl_t                ctl,
    output logic                               sweep_last,
    output logic [phmb_pkg::M_TDATA_W-1:0]     m_tdata
);
    import phmb_pkg::*;

    localparam int CW     = $clog2(MAP_WIDTH);
    localparam int RW     = $clog2(MAP_HEIGHT);
    localparam int ADDR_W = CW + RW;
    localparam int DEPTH  = MAP_HEIGHT * (2 ** CW);
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + CPM_W + 1;
    localparam int FRAC   = 16;
    localparam int Q_W    = PROD_W - 1 - FRAC;

    // Input fields
    logic [1:0]                in_cmd;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic [INDEX_W-1:0]        in_row;
    logic [INDEX_W-1:0]        in_col;

    assign in_cmd = s_tdata[1:0];
    assign in_x   = $signed(s_tdata[33:2]);
    assign in_y   = $signed(s_tdata[65:34]);
    assign in_z   = $signed(s_tdata[97:66]);
    assign in_row = s_tdata[105:98];
    assign in_col = s_tdata[113:106];

    logic [1:0]                cmd_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dz_reg;
    logic [INDEX_W-1:0]        rrow_reg;
    logic [INDEX_W-1:0]        rcol_reg;

    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_z_reg;
    logic signed [CPM_W:0]     cpm_s;

    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         addr_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [INDEX_W-1:0]        row8_reg;
    logic [INDEX_W-1:0]        row8_next;
    logic [INDEX_W-1:0]        col8_reg;
    logic [INDEX_W-1:0]        col8_next;

    logic [COORD_W:0]          mem [DEPTH];
    logic [COORD_W:0]          rdata_reg;
    logic [ADDR_W-1:0]         sweep_cnt_reg;
    logic [M_TDATA_W-1:0]      out_reg;

    // Operand capture: origin offsets held exactly in one extra bit
    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            cmd_reg  <= in_cmd;
            py_reg   <= in_y;
            dx_reg   <= DIFF_W'(in_x) - DIFF_W'(cfg.origin_x);
            dz_reg   <= DIFF_W'(in_z) - DIFF_W'(cfg.origin_z);
            rrow_reg <= in_row;
            rcol_reg <= in_col;
        end
    end

    assign cpm_s = $signed({1'b0, cfg.cells_per_metre});

    always_ff @(posedge aclk) begin
        if (ctl.prod_load) begin
            prod_x_reg <= dx_reg * cpm_s;
            prod_z_reg <= dz_reg * cpm_s;
        end
    end

    // Binning: a negative product floors below zero and is out of the grid
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qz;
    logic [Q_W-1:0] rd_row_ext;
    logic [Q_W-1:0] rd_col_ext;
    logic           x_ok;
    logic           z_ok;
    logic           rd_ok;

    assign qx         = prod_x_reg[FRAC+Q_W-1:FRAC];
    assign qz         = prod_z_reg[FRAC+Q_W-1:FRAC];
    assign x_ok       = !prod_x_reg[PROD_W-1] && (qx < Q_W'(MAP_WIDTH));
    assign z_ok       = !prod_z_reg[PROD_W-1] && (qz < Q_W'(MAP_HEIGHT));
    assign rd_row_ext = Q_W'(rrow_reg);
    assign rd_col_ext = Q_W'(rcol_reg);
    assign rd_ok      = (rd_row_ext < Q_W'(MAP_HEIGHT)) && (rd_col_ext < Q_W'(MAP_WIDTH));

    always_comb begin
        addr_next = '0;
        hit_next  = 1'b0;
        row8_next = '0;
        col8_next = '0;
        case (cmd_reg)
            CMD_INSERT: begin
                addr_next = {qz[RW-1:0], qx[CW-1:0]};
                hit_next  = x_ok && z_ok;
                if (x_ok && z_ok) begin
                    row8_next = qz[INDEX_W-1:0];
                    col8_next = qx[INDEX_W-1:0];
                end
            end
            CMD_READ: begin
                addr_next = {rd_row_ext[RW-1:0], rd_col_ext[CW-1:0]};
                hit_next  = rd_ok;
                row8_next = rrow_reg;
                col8_next = rcol_reg;
            end
            default: hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.bin_load) begin
            addr_reg <= addr_next;
            hit_reg  <= hit_next;
            row8_reg <= row8_next;
            col8_reg <= col8_next;
        end
    end

    // Result and max update
    logic signed [COORD_W-1:0] stored_h;
    logic                      stored_v;
    logic                      upd;
    logic signed [COORD_W-1:0] new_h;
    logic                      mem_wr;
    logic                      res_acc;
    logic                      res_val;
    logic signed [COORD_W-1:0] res_h;
    logic [INDEX_W-1:0]        res_row;
    logic [INDEX_W-1:0]        res_col;

    assign stored_h = $signed(rdata_reg[COORD_W-1:0]);
    assign stored_v = rdata_reg[COORD_W];
    assign upd      = !stored_v || (py_reg > stored_h);
    assign new_h    = upd ? py_reg : stored_h;

    always_comb begin
        mem_wr  = 1'b0;
        res_acc = 1'b0;
        res_val = 1'b0;
        res_h   = '0;
        res_row = '0;
        res_col = '0;
        case (cmd_reg)
            CMD_INSERT: begin
                mem_wr  = hit_reg && upd;
                res_acc = hit_reg;
                res_val = hit_reg;
                res_h   = hit_reg ? new_h : '0;
                res_row = row8_reg;
                res_col = col8_reg;
            end
            CMD_READ: begin
                res_acc = hit_reg;
                res_val = hit_reg && stored_v;
                res_h   = (hit_reg && stored_v) ? stored_h : '0;
                res_row = row8_reg;
                res_col = col8_reg;
            end
            CMD_CLEAR: res_acc = 1'b1;
            default:   res_acc = 1'b0;
        endcase
    end

    // Cell store: valid flag over height, single write port shared with the sweep
    always_ff @(posedge aclk) begin
        if (ctl.clr_step) begin
            mem[sweep_cnt_reg] <= '0;
        end else if (ctl.out_load && mem_wr) begin
            mem[addr_reg] <= {1'b1, new_h};
        end
        if (ctl.mem_rd) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign sweep_last = (sweep_cnt_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (ctl.clr_step) begin
            sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_reg <= {6'b0, res_col, res_row, res_h, res_val, res_acc};
        end
    end

    assign m_tdata = out_reg;

endmodule

### src/point_height_map_binning_core.sv
// Max-height map binning core.
// Input stream (s_*): one command per item - insert a Q16.16 point, read one
// cell, or clear the whole map. Every item produces exactly one result item
// on the output stream (m_*): accepted flag, cell valid flag, cell height,
// row and column.
// Configuration channel (cfg_*): origin_x, origin_z and cells_per_metre,
// written while the core is idle; cfg_ready is always high.
// Insert and read pass through operand capture, scaling multiply, bin/range
// check, cell store read, then the max update and result register; the next
// item is accepted only after the result register step.
// Clear sweeps the cell store one entry per cycle over all
// MAP_HEIGHT * 2**clog2(MAP_WIDTH) entries (65536 at defaults).
// Reset runs the same sweep with no result; s_tready stays low until done.
// A stalled result holds in the output register; the core can take the next
// item meanwhile but holds its own result step until m_tready frees the slot.
module point_height_map_binning_core #(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], point_x[33:2], point_y[65:34], point_z[97:66],
    // read_row[105:98], read_col[113:106]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted[0], cell_valid[1], cell_height[33:2], cell_row[41:34],
    // cell_col[49:42]
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import phmb_pkg::*;

    phmb_cfg_t cfg;
    phmb_ctl_t ctl;
    logic      sweep_last;

    phmb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phmb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_command  (s_tdata[1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sweep_last (sweep_last),
        .ctl        (ctl)
    );

    phmb_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .ctl        (ctl),
        .sweep_last (sweep_last),
        .m_tdata    (m_tdata)
    );

endmodule

### dv/point_height_map_binning_core_checker.sv
`timescale 1ns / 100ps

module point_height_map_binning_core_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [phmb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [phmb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             mismatch_count,
    output int                             cells_pending
);
    import phmb_pkg::*;

    localparam int GRID_W = 256;
    localparam int GRID_H = 256;

    // accepted at bit 0, then cell_valid, cell_height, cell_row, cell_col
    typedef struct packed {
        logic [INDEX_W-1:0]        col;
        logic [INDEX_W-1:0]        row;
        logic signed [COORD_W-1:0] height;
        logic                      valid;
        logic                      acc;
    } cell_report_t;

    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_z;
    logic [CPM_W-1:0]          cpm;
    logic signed [COORD_W-1:0] height_store [GRID_W*GRID_H];
    bit                        cell_filled  [GRID_W*GRID_H];
    cell_report_t              expected_cells [$];

    // floor((p - o) * scale / 2**16), rejected when negative or past the grid edge
    function automatic bit to_bin(input logic signed [COORD_W-1:0] p,
                                  input logic signed [COORD_W-1:0] o,
                                  input logic [CPM_W-1:0] scale, input int limit,
                                  output logic [INDEX_W-1:0] idx);
        longint offset;
        longint scaled;
        longint q;
        offset = longint'(p) - longint'(o);
        scaled = offset * longint'(scale);
        q = scaled >>> 16;
        idx = q[INDEX_W-1:0];
        return (scaled >= 0) && (q < limit);
    endfunction

    function automatic cell_report_t bin_and_update(input logic [S_TDATA_W-1:0] item);
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [INDEX_W-1:0]        r;
        logic [INDEX_W-1:0]        c;
        cell_report_t              rep;
        int                        k;
        rep = '0;
        cmd = item[1:0];
        px  = item[33:2];
        py  = item[65:34];
        pz  = item[97:66];
        case (cmd)
            CMD_INSERT: begin
                if (to_bin(px, origin_x, cpm, GRID_W, c) &&
                    to_bin(pz, origin_z, cpm, GRID_H, r)) begin
                    k = int'(r) * GRID_W + int'(c);
                    // empty cell takes y; filled cell keeps the larger height
                    if (!cell_filled[k] || py > height_store[k]) begin
                        height_store[k] = py;
                        cell_filled[k]  = 1'b1;
                    end
                    rep.acc    = 1'b1;
                    rep.valid  = 1'b1;
                    rep.height = height_store[k];
                    rep.row    = r;
                    rep.col    = c;
                end
            end
            CMD_READ: begin
                r = item[105:98];
                c = item[113:106];
                k = int'(r) * GRID_W + int'(c);
                rep.row = r;
                rep.col = c;
                rep.acc = 1'b1;
                if (cell_filled[k]) begin
                    rep.valid  = 1'b1;
                    rep.height = height_store[k];
                end
            end
            CMD_CLEAR: begin
                cell_filled = '{default: 1'b0};
                rep.acc = 1'b1;
            end
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge aclk) begin
        cell_report_t got;
        cell_report_t want;
        if (!aresetn) begin
            origin_x = '0;
            origin_z = '0;
            cpm      = CPM_RESET;
            cell_filled = '{default: 1'b0};
            expected_cells.delete();
            mismatch_count = 0;
            cells_pending  = 0;
        end else begin
            // retire before taking a new item, so a stray result never matches it
            if (m_tvalid && m_tready) begin
                got = m_tdata[49:0];
                if (expected_cells.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("stray result: acc %0d valid %0d height %0d row %0d col %0d",
                                 got.acc, got.valid, got.height, got.row, got.col);
                end else begin
                    want = expected_cells.pop_front();
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("mismatch: want acc %0d valid %0d height %0d row %0d col %0d",
                                   want.acc, want.valid, want.height, want.row, want.col);
                            $display(", got acc %0d valid %0d height %0d row %0d col %0d",
                                     got.acc, got.valid, got.height, got.row, got.col);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ORIGIN_X:        origin_x = cfg_data;
                    REG_ORIGIN_Z:        origin_z = cfg_data;
                    REG_CELLS_PER_METRE: cpm      = cfg_data[CPM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_cells.insert(expected_cells.size(), bin_and_update(s_tdata));
            cells_pending = expected_cells.size();
        end
    end

endmodule

### dv/point_height_map_binning_core_test.sv
`timescale 1ns / 100ps

module point_height_map_binning_core_test;
    import phmb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 150;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int mismatch_count;
    int cells_pending;

    int                        burst_left = 0;
    bit                        gaps_on    = 1'b1;
    logic signed [COORD_W-1:0] cur_ox     = '0;
    logic signed [COORD_W-1:0] cur_oz     = '0;
    logic [CPM_W-1:0]          cur_cpm    = CPM_RESET;
    logic [INDEX_W-1:0]        pool_row [8];
    logic [INDEX_W-1:0]        pool_col [8];
    logic signed [COORD_W-1:0] height_pool [4];

    int stall_mode   = 0;
    int stall_left   = 0;
    int stall_tick   = 0;
    int stall_period = 2;
    int stall_on     = 1;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    point_height_map_binning_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_height_map_binning_core_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .cells_pending  (cells_pending)
    );

    // receiver: switch between always ready, random, heavy and periodic stalls
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_left   = $urandom_range(16, 256);
            stall_period = $urandom_range(2, 16);
            stall_on     = $urandom_range(1, stall_period - 1);
            stall_tick   = 0;
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_tick % stall_period) < stall_on;
        endcase
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(input logic [1:0] cmd,
                                                       input logic [31:0] px,
                                                       input logic [31:0] py,
                                                       input logic [31:0] pz,
                                                       input logic [7:0] row,
                                                       input logic [7:0] col);
        return {6'b0, col, row, pz, py, px, cmd};
    endfunction

    // coordinate that bins to idx under the current scale, with random offset in the cell
    function automatic logic [31:0] coord_for(input int idx, input logic signed [31:0] org);
        longint c;
        longint lo;
        longint hi;
        longint d;
        longint p;
        c  = longint'(cur_cpm);
        lo = (longint'(idx) * 65536 + c - 1) / c;
        hi = ((longint'(idx) + 1) * 65536 + c - 1) / c - 1;
        d  = lo;
        if (hi > lo)
            d = lo + longint'($urandom_range(0, int'(hi - lo)));
        p = longint'(org) + d;
        return p[31:0];
    endfunction

    // called at a falling edge; returns at the falling edge after the handshake
    task automatic push_item(input logic [S_TDATA_W-1:0] item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic end_stream();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (cells_pending != 0) @(negedge aclk);
    endtask

    task automatic set_config(input logic signed [31:0] ox, input logic signed [31:0] oz,
                              input logic [15:0] cpm);
        logic [1:0]  idx [3];
        logic [31:0] val [3];
        idx = '{REG_ORIGIN_X, REG_ORIGIN_Z, REG_CELLS_PER_METRE};
        val = '{ox, oz, {16'b0, cpm}};
        end_stream();
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_ox  = ox;
        cur_oz  = oz;
        cur_cpm = cpm;
    endtask

    task automatic insert_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        push_item(pack_item(CMD_INSERT, x, y, z, 8'($urandom), 8'($urandom)));
    endtask

    task automatic read_cell(input logic [7:0] row, input logic [7:0] col);
        push_item(pack_item(CMD_READ, $urandom, $urandom, $urandom, row, col));
    endtask

    task automatic clear_map();
        push_item(pack_item(CMD_CLEAR, $urandom, $urandom, $urandom,
                            8'($urandom), 8'($urandom)));
    endtask

    task automatic refresh_pools();
        for (int i = 0; i < 8; i++) begin
            pool_row[i] = 8'($urandom);
            pool_col[i] = 8'($urandom);
        end
        for (int i = 0; i < 4; i++)
            height_pool[i] = $urandom;
        pool_row[0] = '0;
        pool_col[0] = '0;
        pool_row[1] = '1;
        pool_col[1] = '1;
    endtask

    task automatic random_item();
        int          pick;
        int          slot;
        int          row_idx;
        int          col_idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0, 1:    y = $urandom;
            2:       y = height_pool[$urandom_range(0, 3)];
            default: y = height_pool[$urandom_range(0, 3)] + 32'($urandom_range(0, 2)) - 32'd1;
        endcase
        if ($urandom_range(0, 9) < 7) begin
            row_idx = int'(pool_row[slot]);
            col_idx = int'(pool_col[slot]);
        end else begin
            row_idx = $urandom_range(0, 255);
            col_idx = $urandom_range(0, 255);
        end
        x = coord_for(col_idx, cur_ox);
        z = coord_for(row_idx, cur_oz);
        if (pick < 55) begin
            insert_point(x, y, z);
        end else if (pick < 62) begin
            insert_point($urandom, y, $urandom);
        end else if (pick < 68) begin
            // just below the origin on one axis
            if ($urandom_range(0, 1))
                x = cur_ox - $urandom_range(1, 65536);
            else
                z = cur_oz - $urandom_range(1, 65536);
            insert_point(x, y, z);
        end else begin
            read_cell(8'(row_idx), 8'(col_idx));
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        refresh_pools();

        // reset configuration: origin 0, 200 cells per metre
        read_cell(8'd0, 8'd0);
        insert_point(32'd0, 32'h0005_0000, 32'd0);
        insert_point(32'd0, 32'h0000_0001, 32'd0);
        insert_point(32'd0, 32'h0005_0000, 32'd0);
        insert_point(32'd327, 32'h7fff_ffff, 32'd0);
        insert_point(32'hffff_ffff, $urandom, 32'd0);
        insert_point(32'd0, $urandom, 32'hffff_ffff);
        insert_point(32'd83886, 32'h8000_0000, 32'd83886);
        insert_point(32'd83887, $urandom, 32'd0);
        insert_point(32'h7fff_ffff, $urandom, 32'h7fff_ffff);
        insert_point(32'h8000_0000, $urandom, 32'd0);
        read_cell(8'd255, 8'd255);
        read_cell(8'd0, 8'd255);
        read_cell(8'd0, 8'd0);
        clear_map();
        read_cell(8'd0, 8'd0);
        insert_point(32'd0, 32'hffff_fffb, 32'd0);

        set_config(32'sh8000_0000, 32'sh8000_0000, 16'hffff);
        insert_point(32'h8000_0000, $urandom, 32'h8000_0000);
        insert_point(32'h8000_0002, $urandom, 32'h8000_0001);
        insert_point(32'd0, $urandom, 32'h8000_0000);

        set_config(32'sh7fff_ffff, 32'sh7fff_ffff, 16'd1);
        insert_point(32'h7fff_ffff, $urandom, 32'h7fff_ffff);
        insert_point(32'h7fff_fffe, $urandom, 32'h7fff_ffff);
        read_cell(8'd0, 8'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_config('0, '0, CPM_RESET);
                1:       set_config($urandom, $urandom, 16'($urandom_range(1, 65535)));
                2:       set_config(32'sh8000_0000, $urandom, 16'd1);
                default: set_config($urandom, $urandom, 16'hffff);
            endcase
            refresh_pools();
            gaps_on = (phase != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase % 2 == 1 && n == PHASE_ITEMS / 2)
                    clear_map();
                else
                    random_item();
            end
        end

        end_stream();
        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && cells_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
